// File: rtl/prm_pkg.sv
// Shared types, constants and the segment decoder of the pulse rate meter.
// Depends on nothing; pulse_rate_meter_unit imports it.
`default_nettype none

package prm_pkg;

   // Default widths of the tick counters and of the average's fraction.
   localparam int COUNT_WIDTH_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 8;

   // Rate word and its limits.
   localparam int          RATE_WIDTH  = 16;
   localparam int          RATE_MAX    = 65535;
   localparam logic [15:0] SCALE_RESET = 16'd5000;

   // Decimal display: three BCD digits, one bit of the rate per step.
   localparam int DIGIT_COUNT = 3;
   localparam int BCD_WIDTH   = 4 * DIGIT_COUNT;
   localparam int SEG_WIDTH   = 8;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_BCD  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // Active-low seven-segment pattern of one decimal digit.
   function automatic logic [SEG_WIDTH-1:0] seg_pattern(input logic [3:0] digit);
      logic [SEG_WIDTH-1:0] pat;
      begin
         unique case (digit)
            4'd0:    pat = 8'hc0;
            4'd1:    pat = 8'hf9;
            4'd2:    pat = 8'ha4;
            4'd3:    pat = 8'hb0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hd8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h98;
            default: pat = 8'hff;
         endcase
         return pat;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/pulse_rate_meter_unit.sv
// Pulse rate meter: tick counters, period averaging, serial divider and digit sequencer.
// Depends on prm_pkg for constants, the state type and the segment decoder.
//
// Usage:
//   One beat on the req_ channel carries one sampled pulse level (one tick). Every
//   accepted tick yields exactly one beat on the rsp_ channel with the held rate,
//   a flag that marks a rising edge, and the segment patterns of the rate's low
//   three decimal digits. A ready/valid csr_ channel writes scale_numerator; it
//   is ready only while the sequencer is idle, no beat waits and no tick is offered.
//   A tick without a rising edge goes straight to the output step, which moves its
//   result into the output register. A rising edge runs the restoring divider over
//   16 + FRACTION_BITS numerator bits (one quotient bit per cycle on one shared
//   subtract-compare), then a binary-to-BCD pass over the 16 rate bits; a zero
//   average skips the division. Throughput: one tick at a time; req_stall stays
//   high from acceptance until the result has been moved into the output register.
//   The output register holds a finished beat while rsp_stall is high, and the
//   next tick is already accepted meanwhile; that tick waits in its last step.
//   Reset (synchronous, active high) clears the counters, the average, the held
//   rate and restores scale_numerator to 5000.
`default_nettype none

module pulse_rate_meter_unit #(
   parameter int COUNT_WIDTH   = prm_pkg::COUNT_WIDTH_DEF,
   parameter int FRACTION_BITS = prm_pkg::FRACTION_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Tick input channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_pulse_level,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_rate_value,
   output logic             rsp_rate_updated,
   output logic [7:0]       rsp_seg_hundreds,
   output logic [7:0]       rsp_seg_tens,
   output logic [7:0]       rsp_seg_ones,
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_scale_numerator
);
   import prm_pkg::*;

   localparam int CW  = COUNT_WIDTH;
   localparam int AW  = COUNT_WIDTH + 1 + FRACTION_BITS;   // average width
   localparam int NW  = RATE_WIDTH + FRACTION_BITS;        // numerator width
   localparam int DCW = $clog2(NW);                        // divider step counter
   localparam int BCW = $clog2(RATE_WIDTH);                // BCD step counter

   // Registers and their next values.
   state_type              state_ff, state_in;
   logic [15:0]            scale_ff, scale_in;
   logic                   phase_high_ff, phase_high_in;
   logic                   edge_seen_ff, edge_seen_in;
   logic [CW-1:0]          high_ff, high_in;
   logic [CW-1:0]          low_ff, low_in;
   logic [AW-1:0]          avg_ff, avg_in;
   logic [RATE_WIDTH-1:0]  rate_ff, rate_in;
   logic                   upd_ff, upd_in;
   logic [AW-1:0]          rem_ff, rem_in;
   logic [NW-1:0]          num_ff, num_in;
   logic [NW-1:0]          quo_ff, quo_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic [RATE_WIDTH-1:0]  bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCW-1:0]         bcnt_ff, bcnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic [15:0]            out_rate_ff, out_rate_in;
   logic                   out_upd_ff, out_upd_in;
   logic [7:0]             out_hun_ff, out_hun_in;
   logic [7:0]             out_ten_ff, out_ten_in;
   logic [7:0]             out_one_ff, out_one_in;

   // Combinational helpers.
   logic                   req_take;
   logic                   out_free;
   logic [CW-1:0]          high_inc, low_inc, low_cur;
   logic [CW:0]            period_sum;
   logic [AW:0]            avg_sum;
   logic [AW:0]            trial;
   logic [AW:0]            trial_diff;
   logic                   quo_bit;
   logic [NW-1:0]          quo_next;
   logic [BCD_WIDTH-1:0]   bcd_adj;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !out_valid_ff && !req_valid;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Saturating tick counters and the running period average.
   assign high_inc   = (high_ff == {CW{1'b1}}) ? high_ff : high_ff + 1'b1;
   assign low_inc    = (low_ff == {CW{1'b1}}) ? low_ff : low_ff + 1'b1;
   assign low_cur    = edge_seen_ff ? low_inc : low_ff;
   assign period_sum = {1'b0, high_ff} + {1'b0, low_cur};
   assign avg_sum    = {1'b0, avg_ff} + ((AW+1)'(period_sum) << FRACTION_BITS);

   // One restoring division step: shift in a numerator bit, subtract if it fits.
   assign trial      = {rem_ff, num_ff[NW-1]};
   assign trial_diff = trial - {1'b0, avg_ff};
   assign quo_bit    = (trial >= {1'b0, avg_ff});
   assign quo_next   = {quo_ff[NW-2:0], quo_bit};

   // Add three to every BCD digit of five or more before the next shift.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in      = state_ff;
      scale_in      = scale_ff;
      phase_high_in = phase_high_ff;
      edge_seen_in  = edge_seen_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      avg_in        = avg_ff;
      rate_in       = rate_ff;
      upd_in        = upd_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      bcnt_in       = bcnt_ff;
      out_valid_in  = out_valid_ff;
      out_rate_in   = out_rate_ff;
      out_upd_in    = out_upd_ff;
      out_hun_in    = out_hun_ff;
      out_ten_in    = out_ten_ff;
      out_one_in    = out_one_ff;

      // A beat taken by the receiver empties the output register.
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         scale_in = csr_scale_numerator;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               upd_in   = 1'b0;
               state_in = ST_OUT;
               if (phase_high_ff) begin
                  high_in = high_inc;
                  if (!req_pulse_level) begin
                     phase_high_in = 1'b0;
                  end
               end else if (req_pulse_level) begin
                  // Rising edge: fold the period into the average, restart counts.
                  edge_seen_in  = 1'b1;
                  upd_in        = 1'b1;
                  avg_in        = avg_sum[AW:1];
                  high_in       = CW'(1);
                  low_in        = '0;
                  phase_high_in = 1'b1;
                  rem_in        = '0;
                  num_in        = NW'(scale_ff) << FRACTION_BITS;
                  quo_in        = '0;
                  dcnt_in       = '0;
                  state_in      = ST_DIV;
               end else begin
                  low_in = low_cur;
               end
            end
         end
         ST_DIV: begin
            if (avg_ff == '0) begin
               rate_in  = RATE_WIDTH'(RATE_MAX);
               bin_in   = RATE_WIDTH'(RATE_MAX);
               bcd_in   = '0;
               bcnt_in  = '0;
               state_in = ST_BCD;
            end else begin
               if (quo_bit) begin
                  rem_in = trial_diff[AW-1:0];
               end else begin
                  rem_in = trial[AW-1:0];
               end
               num_in  = {num_ff[NW-2:0], 1'b0};
               quo_in  = quo_next;
               dcnt_in = dcnt_ff + 1'b1;
               if (dcnt_ff == DCW'(NW-1)) begin
                  // Last quotient bit: saturate and start the digit pass.
                  if (quo_next > NW'(RATE_MAX)) begin
                     rate_in = RATE_WIDTH'(RATE_MAX);
                     bin_in  = RATE_WIDTH'(RATE_MAX);
                  end else begin
                     rate_in = quo_next[RATE_WIDTH-1:0];
                     bin_in  = quo_next[RATE_WIDTH-1:0];
                  end
                  bcd_in   = '0;
                  bcnt_in  = '0;
                  state_in = ST_BCD;
               end
            end
         end
         ST_BCD: begin
            // Carries out of the hundreds digit are dropped: rate mod 1000.
            bcd_in  = {bcd_adj[BCD_WIDTH-2:0], bin_ff[RATE_WIDTH-1]};
            bin_in  = {bin_ff[RATE_WIDTH-2:0], 1'b0};
            bcnt_in = bcnt_ff + 1'b1;
            if (bcnt_ff == BCW'(RATE_WIDTH-1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_rate_in  = rate_ff;
               out_upd_in   = upd_ff;
               out_hun_in   = seg_pattern(bcd_ff[11:8]);
               out_ten_in   = seg_pattern(bcd_ff[7:4]);
               out_one_in   = seg_pattern(bcd_ff[3:0]);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and held state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scale_ff      <= SCALE_RESET;
         phase_high_ff <= 1'b0;
         edge_seen_ff  <= 1'b0;
         high_ff       <= '0;
         low_ff        <= '0;
         avg_ff        <= '0;
         rate_ff       <= '0;
         bcd_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         phase_high_ff <= phase_high_in;
         edge_seen_ff  <= edge_seen_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         avg_ff        <= avg_in;
         rate_ff       <= rate_in;
         bcd_ff        <= bcd_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Working registers of the divider and digit pass, and the output payload.
   always_ff @(posedge clock) begin
      upd_ff      <= upd_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      bin_ff      <= bin_in;
      bcnt_ff     <= bcnt_in;
      out_rate_ff <= out_rate_in;
      out_upd_ff  <= out_upd_in;
      out_hun_ff  <= out_hun_in;
      out_ten_ff  <= out_ten_in;
      out_one_ff  <= out_one_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_rate_value   = out_rate_ff;
   assign rsp_rate_updated = out_upd_ff;
   assign rsp_seg_hundreds = out_hun_ff;
   assign rsp_seg_tens     = out_ten_ff;
   assign rsp_seg_ones     = out_one_ff;

endmodule

`default_nettype wire
